>>> rtl/stls_pkg.sv
// Package for the sequential turn light stepper.
// Holds widths, register indexes, request codes and reset values.
// No dependencies.
package stls_pkg;

  localparam int LED_COUNT   = 8;
  localparam int PHASE_COUNT = LED_COUNT + 1;
  localparam int PHASE_W     = $clog2(PHASE_COUNT);
  localparam int LED_W       = 8;
  localparam int COIL_W      = 4;
  localparam int CNT_W       = 8;
  localparam int TICK_W      = 24;
  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_W        = 8;
  localparam int USER_W      = 2;
  localparam int OUT_W       = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_PHASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD     = 2'd2;

  localparam logic [CNT_W-1:0]  RESET_REPEAT_COUNT    = 8'd5;
  localparam logic [CNT_W-1:0]  RESET_STEPS_PER_PHASE = 8'd30;
  localparam logic [TICK_W-1:0] RESET_STEP_PERIOD     = 24'd10000;

  localparam logic [LED_W-1:0] LED_ALL_OFF = 8'hFF;

  typedef enum logic [USER_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_LEFT  = 2'd1,
    REQ_RIGHT = 2'd2
  } req_t;

endpackage

>>> rtl/sequential_turn_light_stepper.sv
// Sequential turn light stepper: request latching, light sweep and stepper sequencing.
// Depends on stls_pkg.
// A result word is registered in the output register, or in the skid word while that register is stalled.
// Throughput: one word per cycle while the skid word is empty; a two-word output stage
// (register plus skid) keeps input accepted while one result waits.
// Reset (rst, synchronous): no pending requests, idle, coil index 0, output empty,
// registers back to 5 sweeps, 30 steps per phase, 10000 ticks per step.
module sequential_turn_light_stepper
  import stls_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,   // [0] pin_low
  input  logic [USER_W-1:0]    s_tuser,   // [1:0] req_type
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // [7:0] led_drive, [11:8] coil_drive,
                                          // [12] busy_res, [13] turning_right
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CNT_W-1:0]   repeat_count;
  logic [CNT_W-1:0]   steps_per_phase;
  logic [TICK_W-1:0]  step_period;

  logic               left_pending, left_pending_next;
  logic               right_pending, right_pending_next;
  logic               running, running_next;
  logic               dir_right, dir_right_next;
  logic [CNT_W-1:0]   rep_counter, rep_counter_next;
  logic [PHASE_W-1:0] phase_counter, phase_counter_next;
  logic [CNT_W-1:0]   step_counter, step_counter_next;
  logic [TICK_W-1:0]  tick_counter, tick_counter_next;
  logic [1:0]         coil_index, coil_index_next;

  logic               accept;
  logic               out_take;
  logic               skid_valid;
  logic [OUT_W-1:0]   skid_data;
  logic [OUT_W-1:0]   result;
  logic [LED_W-1:0]   led_drive;
  logic [COIL_W-1:0]  coil_drive;
  logic               pin_low;

  assign pin_low  = s_tdata[0];
  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign out_take = m_tvalid && m_tready;

  always_comb begin
    left_pending_next  = left_pending;
    right_pending_next = right_pending;
    running_next       = running;
    dir_right_next     = dir_right;
    rep_counter_next   = rep_counter;
    phase_counter_next = phase_counter;
    step_counter_next  = step_counter;
    tick_counter_next  = tick_counter;
    coil_index_next    = coil_index;
    case (req_t'(s_tuser))
      REQ_LEFT: begin
        if (pin_low) left_pending_next = 1'b1;
      end
      REQ_RIGHT: begin
        if (pin_low) right_pending_next = 1'b1;
      end
      REQ_TICK: begin
        if (!running) begin
          if (left_pending || right_pending) begin
            dir_right_next = !left_pending;
            if (left_pending) begin
              left_pending_next = 1'b0;
            end else begin
              right_pending_next = 1'b0;
            end
            running_next       = 1'b1;
            rep_counter_next   = '0;
            phase_counter_next = '0;
            step_counter_next  = '0;
            tick_counter_next  = '0;
            coil_index_next    = left_pending ? coil_index + 2'd1 : coil_index - 2'd1;
          end
        end else if (({1'b0, tick_counter} + 25'd1) >= {1'b0, step_period}) begin
          tick_counter_next = '0;
          if (({1'b0, step_counter} + 9'd1) >= {1'b0, steps_per_phase}) begin
            step_counter_next = '0;
            if (phase_counter == PHASE_W'(PHASE_COUNT - 1)) begin
              phase_counter_next = '0;
              if (({1'b0, rep_counter} + 9'd1) >= {1'b0, repeat_count}) begin
                rep_counter_next = '0;
                running_next     = 1'b0;
              end else begin
                rep_counter_next = rep_counter + 8'd1;
              end
            end else begin
              phase_counter_next = phase_counter + PHASE_W'(1);
            end
          end else begin
            step_counter_next = step_counter + 8'd1;
          end
          if (running_next) begin
            coil_index_next = dir_right ? coil_index - 2'd1 : coil_index + 2'd1;
          end
        end else begin
          tick_counter_next = tick_counter + 24'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // thermometer bar over the LED bank, from bit 0 for left, from the top bit for right, active low
  always_comb begin
    for (int i = 0; i < LED_W; i++) begin
      logic lit;
      lit = (int'(phase_counter_next) < LED_COUNT) &&
            (dir_right_next ? (i + int'(phase_counter_next) >= LED_COUNT - 1)
                            : (i <= int'(phase_counter_next)));
      led_drive[i] = (i < LED_COUNT) ? !(running_next && lit) : 1'b0;
    end
    coil_drive = running_next ? (COIL_W'(1) << coil_index_next) : '0;
    result = {2'b00, running_next && dir_right_next, running_next, coil_drive, led_drive};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_count    <= RESET_REPEAT_COUNT;
      steps_per_phase <= RESET_STEPS_PER_PHASE;
      step_period     <= RESET_STEP_PERIOD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REPEAT_COUNT:    repeat_count    <= cfg_data[CNT_W-1:0];
        CFG_STEPS_PER_PHASE: steps_per_phase <= cfg_data[CNT_W-1:0];
        CFG_STEP_PERIOD:     step_period     <= cfg_data[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pending  <= 1'b0;
      right_pending <= 1'b0;
      running       <= 1'b0;
      dir_right     <= 1'b0;
      rep_counter   <= '0;
      phase_counter <= '0;
      step_counter  <= '0;
      tick_counter  <= '0;
      coil_index    <= '0;
    end else if (accept) begin
      left_pending  <= left_pending_next;
      right_pending <= right_pending_next;
      running       <= running_next;
      dir_right     <= dir_right_next;
      rep_counter   <= rep_counter_next;
      phase_counter <= phase_counter_next;
      step_counter  <= step_counter_next;
      tick_counter  <= tick_counter_next;
      coil_index    <= coil_index_next;
    end
  end

  // output register plus skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !m_tvalid) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
      end else if (accept) begin
        m_tdata <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

endmodule

>>> rtl/stls_checker.sv
// Port-level checker for sequential_turn_light_stepper, bound to the top level.
// Depends on stls_pkg.
module stls_sva
  import stls_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [OUT_W-1:0]     m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_idle_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[12]) |->
      (m_tdata[7:0] == LED_ALL_OFF && m_tdata[11:8] == 4'd0 && !m_tdata[13]))
    else $error("idle word not all off");

  a_run_coil: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[12]) |-> $onehot(m_tdata[11:8]))
    else $error("coil drive not one-hot during a run");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output word changed");

endmodule

bind sequential_turn_light_stepper stls_sva u_stls_sva (.*);
